[design/soc_pkg.sv]
// Shared types, codes and helpers for the sphere against oriented box contact block.
package soc_pkg;

  // Fraction bits of the signed fixed-point format.
  localparam int FracBits = 16;
  // Multiplier operand width: 32-bit signed values and 32-bit magnitudes.
  localparam int MulW = 33;
  // Accumulator width: holds a sum of three full products without overflow.
  localparam int AccW = 2 * MulW + 1;
  // Width of the world-frame offset sum (three floored products).
  localparam int WorldW = 52;
  // Number of square root iterations, one result bit each.
  localparam int SqrtSteps = 32;

  localparam logic [2:0] OP_ROW0 = 3'd0;
  localparam logic [2:0] OP_ROW1 = 3'd1;
  localparam logic [2:0] OP_ROW2 = 3'd2;
  localparam logic [2:0] OP_POS  = 3'd3;
  localparam logic [2:0] OP_SIZE = 3'd4;
  localparam logic [2:0] OP_TEST = 3'd5;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic [30:0]        sphere_radius;
  } in_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic signed [31:0] depth;
    logic signed [31:0] local_x;
    logic signed [31:0] local_y;
    logic signed [31:0] local_z;
  } out_t;

  // Which product series the shared multiplier is working on.
  typedef enum logic [1:0] {
    SEL_LOC   = 2'd0,
    SEL_SQ    = 2'd1,
    SEL_WORLD = 2'd2
  } sel_t;

  typedef struct packed {
    logic       cfg_wr;
    logic       start;
    logic       mul_issue;
    sel_t       sel;
    logic [1:0] inner;
    logic [1:0] outer;
    logic       clamp_en;
    logic       sqrt_step;
    logic       fin_load;
  } cmd_t;

  // Saturates a wide signed value to the 32-bit signed range.
  function automatic logic signed [31:0] sat32(input logic signed [AccW-1:0] x);
    if (x[AccW-1:31] == '0 || x[AccW-1:31] == '1) begin
      return x[31:0];
    end else if (x[AccW-1]) begin
      return 32'sh8000_0000;
    end else begin
      return 32'sh7fff_ffff;
    end
  endfunction

endpackage

[design/soc_dp.sv]
// Datapath: box registers, shared multiplier and accumulator, clamp, square root and result.
module soc_dp import soc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  in_t  in_data,
  input  cmd_t cmd,
  output out_t out_data
);

  logic signed [31:0]       rot_r [9];
  logic signed [31:0]       pos_r [3];
  logic signed [31:0]       size_r [3];
  logic signed [31:0]       vin [3];
  logic signed [32:0]       vp_w [3];
  logic signed [32:0]       vp_r [3];
  logic signed [31:0]       diff_r [3];
  logic [30:0]              rad_in_r;
  logic signed [31:0]       loc_r [3];
  logic signed [31:0]       pt_r [3];
  logic [31:0]              d_r [3];
  logic signed [WorldW-1:0] w_r [3];
  logic [3:0]               rix_loc, rix_world;
  logic signed [MulW-1:0]   ma, mb;
  logic signed [2*MulW-1:0] p_r;
  logic                     pv_r;
  sel_t                     ps_r;
  logic [1:0]               pi_r, po_r;
  logic signed [AccW-1:0]   acc_r, term, acc_sum;
  logic [63:0]              sq_r;
  logic [35:0]              rem_r, rem_sh, trial;
  logic [31:0]              root_r;
  logic signed [31:0]       half, lv;
  logic signed [32:0]       neg_half, ptc, dd;
  logic                     hit;
  out_t                     out_nxt;
  out_t                     out_r;

  assign vin[0] = in_data.vec_x;
  assign vin[1] = in_data.vec_y;
  assign vin[2] = in_data.vec_z;

  always_comb begin
    for (int n = 0; n < 3; n++) begin
      vp_w[n] = 33'(vin[n]) - 33'(pos_r[n]);
    end
  end

  // Box state, written by the load transactions.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < 9; n++) rot_r[n] <= '0;
      for (int n = 0; n < 3; n++) begin
        pos_r[n]  <= '0;
        size_r[n] <= '0;
      end
    end else if (cmd.cfg_wr) begin
      unique case (in_data.operation)
        OP_ROW0: begin
          rot_r[0] <= vin[0]; rot_r[1] <= vin[1]; rot_r[2] <= vin[2];
        end
        OP_ROW1: begin
          rot_r[3] <= vin[0]; rot_r[4] <= vin[1]; rot_r[5] <= vin[2];
        end
        OP_ROW2: begin
          rot_r[6] <= vin[0]; rot_r[7] <= vin[1]; rot_r[8] <= vin[2];
        end
        OP_POS: begin
          for (int n = 0; n < 3; n++) pos_r[n] <= vin[n];
        end
        OP_SIZE: begin
          for (int n = 0; n < 3; n++) size_r[n] <= vin[n];
        end
        default: ;
      endcase
    end
  end

  // Test transaction operands.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rad_in_r <= in_data.sphere_radius;
      for (int n = 0; n < 3; n++) begin
        vp_r[n]   <= vp_w[n];
        diff_r[n] <= sat32(AccW'(vp_w[n]));
      end
    end
  end

  // Operand selection for the shared multiplier.
  assign rix_loc   = 4'({cmd.outer, 1'b0}) + 4'(cmd.outer) + 4'(cmd.inner);
  assign rix_world = 4'({cmd.inner, 1'b0}) + 4'(cmd.inner) + 4'(cmd.outer);

  always_comb begin
    case (cmd.sel)
      SEL_LOC: begin
        ma = MulW'(diff_r[cmd.inner]);
        mb = MulW'(rot_r[rix_loc]);
      end
      SEL_SQ: begin
        ma = {1'b0, d_r[cmd.inner]};
        mb = {1'b0, d_r[cmd.inner]};
      end
      SEL_WORLD: begin
        ma = MulW'(pt_r[cmd.inner]);
        mb = MulW'(rot_r[rix_world]);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= cmd.mul_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_issue) begin
      p_r  <= ma * mb;
      ps_r <= cmd.sel;
      pi_r <= cmd.inner;
      po_r <= cmd.outer;
    end
  end

  // Squares are summed raw; the other products are floored to the fixed-point scale.
  assign term    = (ps_r == SEL_SQ) ? AccW'(p_r) : AccW'(p_r >>> FracBits);
  assign acc_sum = (pi_r == 2'd0) ? term : acc_r + term;

  // Restoring square root, one result bit per step.
  assign rem_sh = {rem_r[33:0], sq_r[63:62]};
  assign trial  = rem_sh - {2'b00, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (pv_r) begin
      acc_r <= acc_sum;
      if (pi_r == 2'd2) begin
        case (ps_r)
          SEL_LOC: loc_r[po_r] <= sat32(acc_sum);
          SEL_SQ: begin
            sq_r   <= (acc_sum[AccW-1:64] != '0) ? '1 : acc_sum[63:0];
            rem_r  <= '0;
            root_r <= '0;
          end
          SEL_WORLD: w_r[po_r] <= acc_sum[WorldW-1:0];
          default: ;
        endcase
      end
    end else if (cmd.sqrt_step) begin
      sq_r <= {sq_r[61:0], 2'b00};
      if (!trial[35]) begin
        rem_r  <= trial;
        root_r <= {root_r[30:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[30:0], 1'b0};
      end
    end
  end

  // Clamp of one local coordinate per cycle; the later lower-bound test wins.
  always_comb begin
    half     = size_r[cmd.inner] >>> 1;
    lv       = loc_r[cmd.inner];
    neg_half = -33'(half);
    ptc      = 33'(lv);
    if (lv > half) ptc = 33'(half);
    if (33'(lv) < neg_half) ptc = neg_half;
    dd = ptc - 33'(lv);
  end

  always_ff @(posedge clk) begin
    if (cmd.clamp_en) begin
      pt_r[cmd.inner] <= ptc[31:0];
      d_r[cmd.inner]  <= dd[32] ? 32'(-dd) : dd[31:0];
    end
  end

  assign hit = (root_r != '0) && ({1'b0, root_r} < {2'b00, rad_in_r});

  // A miss reports all fields as zero.
  always_comb begin
    out_nxt = '0;
    if (hit) begin
      out_nxt.hit      = 1'b1;
      out_nxt.normal_x = sat32(AccW'(vp_r[0]) - AccW'(w_r[0]));
      out_nxt.normal_y = sat32(AccW'(vp_r[1]) - AccW'(w_r[1]));
      out_nxt.normal_z = sat32(AccW'(vp_r[2]) - AccW'(w_r[2]));
      out_nxt.depth    = 32'(33'(rad_in_r) - 33'(root_r));
      out_nxt.local_x  = pt_r[0];
      out_nxt.local_y  = pt_r[1];
      out_nxt.local_z  = pt_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_load) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule

[design/soc_ctrl.sv]
// Controller: sequences the multiplier series, clamp, square root and result hand-off.
module soc_ctrl import soc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [2:0] in_op,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output cmd_t       cmd
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b000_0001,
    ST_LOC   = 7'b000_0010,
    ST_CLAMP = 7'b000_0100,
    ST_SQ    = 7'b000_1000,
    ST_SQRT  = 7'b001_0000,
    ST_WORLD = 7'b010_0000,
    ST_FIN   = 7'b100_0000
  } state_t;

  state_t     state_r, state_nxt;
  logic [5:0] k_r, k_nxt;
  logic [1:0] inner_r, inner_nxt, outer_r, outer_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept, slot_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    inner_nxt     = inner_r;
    outer_nxt     = outer_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.sel       = SEL_LOC;
    cmd.inner     = inner_r;
    cmd.outer     = outer_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_op == OP_TEST) begin
            cmd.start = 1'b1;
            state_nxt = ST_LOC;
            k_nxt     = '0;
            inner_nxt = '0;
            outer_nxt = '0;
          end else begin
            cmd.cfg_wr = 1'b1;
          end
        end
      end
      ST_LOC, ST_SQ, ST_WORLD: begin
        cmd.sel = (state_r == ST_LOC) ? SEL_LOC :
                  (state_r == ST_SQ)  ? SEL_SQ  : SEL_WORLD;
        if ((state_r == ST_SQ && k_r < 6'd3) || (state_r != ST_SQ && k_r < 6'd9)) begin
          cmd.mul_issue = 1'b1;
          k_nxt         = k_r + 6'd1;
          if (inner_r == 2'd2) begin
            inner_nxt = '0;
            outer_nxt = outer_r + 2'd1;
          end else begin
            inner_nxt = inner_r + 2'd1;
          end
        end else begin
          // The last product has been accumulated in this cycle.
          k_nxt     = '0;
          inner_nxt = '0;
          outer_nxt = '0;
          state_nxt = (state_r == ST_LOC) ? ST_CLAMP :
                      (state_r == ST_SQ)  ? ST_SQRT  : ST_FIN;
        end
      end
      ST_CLAMP: begin
        cmd.clamp_en = 1'b1;
        if (inner_r == 2'd2) begin
          inner_nxt = '0;
          state_nxt = ST_SQ;
        end else begin
          inner_nxt = inner_r + 2'd1;
        end
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (k_r == 6'(SqrtSteps - 1)) begin
          k_nxt     = '0;
          state_nxt = ST_WORLD;
        end else begin
          k_nxt = k_r + 6'd1;
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          cmd.fin_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      inner_r     <= '0;
      outer_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      inner_r     <= inner_nxt;
      outer_r     <= outer_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A test transaction always starts with the transform series.
  a_start_loc: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> state_r == ST_LOC)
    else $error("test transaction did not enter the transform series");

  // A result is never loaded over one that is still held by a stalled consumer.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin_load |-> !(out_valid_r && out_stall))
    else $error("result register overwritten while stalled");

  // A loaded result is presented in the next cycle.
  a_fin_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin_load |=> out_valid_r)
    else $error("loaded result not presented");

  // The square root runs its full length before the world-frame series.
  a_sqrt_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SQRT && k_r == 6'(SqrtSteps - 1)) |=> state_r == ST_WORLD)
    else $error("square root sequence length wrong");

endmodule

[design/sphere_obb_contact.sv]
// Top level of the sphere against oriented box contact block.
//
//   channel   direction  handshake            payload
//   in_       input      in_valid / in_stall    in_t  (operation, vector, radius)
//   out_      output     out_valid / out_stall  out_t (hit, normal, depth, local point)
//
// Load transactions (rotation rows, position, size) are written in the cycle they are
// accepted. A test transaction then runs these steps in order up to a loaded result: nine
// products on the shared 33x33 multiplier for the box-frame transform, a clamp of each
// local coordinate, three squares, 32 square root iterations and nine products for the
// world-frame point, with an accumulate step after each product series and a hand-off step.
// The next transaction is accepted in the cycle after the result is loaded, not before.
// The shared multiplier and the bit-serial square root set the length of a test.
// Reset is synchronous and active low; it clears the box state to zero and the control.
// The result sits in an output register, so the next transaction is accepted while a
// finished result is still stalled; a new result waits until that register is free.
module sphere_obb_contact import soc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  cmd_t cmd;

  // The controller sequences every step; the datapath only follows its commands.
  soc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_data.operation),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // All arithmetic and storage of the box, the test operands and the result.
  soc_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .out_data (out_data)
  );

endmodule
